// ===== rtl/core/lobm_pkg.sv =====
package lobm_pkg;

    localparam int LOBM_MAX_ORDERS = 63;

    // Request kinds.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;

    // Order types.
    localparam logic [1:0] OT_FAK    = 2'd1;
    localparam logic [1:0] OT_MARKET = 2'd2;

    // Closing status codes.
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_DUP     = 3'd1;
    localparam logic [2:0] STS_NOLIQ   = 3'd2;
    localparam logic [2:0] STS_UNKNOWN = 3'd3;
    localparam logic [2:0] STS_FULL    = 3'd4;

    // One resting order as stored in the slot memory.
    typedef struct packed {
        logic [31:0] id;
        logic        side;
        logic        fak;
        logic [31:0] price;
        logic [31:0] rem;
        logic [63:0] arrival;
    } t_slot;

    // Best order of one side found by a table scan.
    typedef struct packed {
        logic  vld;
        t_slot s;
    } t_best;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_WORST,
        S_ALLOC,
        S_SCAN,
        S_TRADE,
        S_WR_BID,
        S_WR_ASK,
        S_FAK,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/lobm_req_if.sv =====
interface lobm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] order_id;
    logic        side;
    logic [1:0]  order_type;
    logic [31:0] price;
    logic [31:0] quantity;

    modport source (output valid, kind, order_id, side, order_type, price, quantity,
                    input ready);
    modport sink   (input valid, kind, order_id, side, order_type, price, quantity,
                    output ready);
endinterface

// ===== rtl/core/lobm_res_if.sv =====
interface lobm_res_if;
    logic        valid;
    logic        ready;
    logic        is_trade;
    logic [31:0] bid_id;
    logic [31:0] bid_price;
    logic [31:0] ask_id;
    logic [31:0] ask_price;
    logic [31:0] fill_quantity;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, is_trade, bid_id, bid_price, ask_id, ask_price,
                    fill_quantity, status, last, input ready);
    modport sink   (input valid, is_trade, bid_id, bid_price, ask_id, ask_price,
                    fill_quantity, status, last, output ready);
endinterface

// ===== rtl/core/limit_order_book_matcher.sv =====
// Flow: an id lookup pass, a further pass for a market order to find the worst
// opposite price, then a book pass before each trade and a final book pass.
// One request is handled at a time; a cancel takes only the lookup pass. Each pass
// reads the slot memory one entry per cycle through its one read port.
// Reset (synchronous, active low) empties the book and zeroes the arrival counter.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int MAX_ORDERS = LOBM_MAX_ORDERS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lobm_req_if.sink   i_req,
    lobm_res_if.source o_res
);

    localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CW = $clog2(MAX_ORDERS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ORDERS - 1);

    // Slot payload lives in one synchronous memory; only the valid bits are flops,
    // so that reset empties the book at once.
    t_slot mem [MAX_ORDERS];
    logic [MAX_ORDERS-1:0] r_valid;

    t_state r_state, n_state;

    // Captured request.
    logic [1:0]  r_kind;
    logic [31:0] r_id;
    logic        r_side;
    logic [1:0]  r_type;
    logic [31:0] r_price;
    logic [31:0] r_qty;
    logic        r_fak;
    logic [2:0]  r_status;
    logic [63:0] r_arrival;

    // Scan pipeline: an address is issued each cycle and its data is examined the
    // cycle after, tagged with the index it came from.
    logic [CW-1:0] r_iss;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    t_slot         r_rd;

    // Lookup and worst-price results.
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_hit_fak;
    logic          r_wfound;
    logic [31:0]   r_wprice;

    // Best bid and best ask of the last book pass.
    t_best         r_bb, r_ba;
    logic [IW-1:0] r_bi, r_ai;
    logic [31:0]   r_q;

    // Output register.
    logic        r_ov;
    logic        r_o_trade;
    logic [31:0] r_o_bid_id, r_o_bid_price, r_o_ask_id, r_o_ask_price, r_o_fill;
    logic [2:0]  r_o_status;
    logic        r_o_last;

    logic          out_free;
    logic          scan_end;
    logic          slot_ok;
    logic          scan_start;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_slot         mem_wd;
    logic          emit_trade, emit_stat;
    logic [31:0]   q_min;
    logic          crossed;

    assign out_free = !r_ov || o_res.ready;
    assign scan_end = r_pv && (r_pidx == LAST_IDX);
    assign slot_ok  = r_pv && r_valid[r_pidx];
    assign q_min    = (r_bb.s.rem < r_ba.s.rem) ? r_bb.s.rem : r_ba.s.rem;
    assign crossed  = r_bb.vld && r_ba.vld && (r_bb.s.price >= r_ba.s.price);
    assign scan_start = (n_state != r_state) &&
                        (n_state == S_FIND || n_state == S_WORST || n_state == S_SCAN);

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.kind == KIND_ADD || i_req.kind == KIND_CANCEL ||
                        i_req.kind == KIND_MODIFY) begin
                        n_state = S_FIND;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIND: begin
                if (scan_end) begin
                    if (r_kind == KIND_CANCEL) begin
                        n_state = S_DONE;
                    end else if (r_kind == KIND_MODIFY) begin
                        n_state = (r_hit || (slot_ok && r_rd.id == r_id)) ? S_ALLOC : S_DONE;
                    end else if (r_hit || (slot_ok && r_rd.id == r_id)) begin
                        n_state = S_DONE;
                    end else if (r_type == OT_MARKET) begin
                        n_state = S_WORST;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
            end
            S_WORST: begin
                if (scan_end) begin
                    n_state = (r_wfound || (slot_ok && r_rd.side != r_side)) ? S_ALLOC : S_DONE;
                end
            end
            S_ALLOC:  n_state = free_found ? S_SCAN : S_DONE;
            S_SCAN:   if (scan_end) n_state = S_TRADE;
            S_TRADE: begin
                if (!crossed) begin
                    n_state = S_FAK;
                end else if (out_free) begin
                    n_state = S_WR_BID;
                end
            end
            S_WR_BID: n_state = S_WR_ASK;
            S_WR_ASK: n_state = S_SCAN;
            S_FAK:    n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = r_bb.s;
        emit_trade = 1'b0;
        emit_stat  = 1'b0;
        case (r_state)
            S_ALLOC: begin
                mem_we = free_found;
                mem_wa = free_idx;
                mem_wd = '{id: r_id, side: r_side, fak: r_fak, price: r_price,
                           rem: r_qty, arrival: r_arrival};
            end
            S_TRADE: emit_trade = crossed && out_free;
            S_WR_BID: begin
                mem_we     = 1'b1;
                mem_wa     = r_bi;
                mem_wd     = r_bb.s;
                mem_wd.rem = r_bb.s.rem - r_q;
            end
            S_WR_ASK: begin
                mem_we     = 1'b1;
                mem_wa     = r_ai;
                mem_wd     = r_ba.s;
                mem_wd.rem = r_ba.s.rem - r_q;
            end
            S_DONE:  emit_stat = out_free;
            default: emit_stat = 1'b0;
        endcase
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_iss[IW-1:0]];
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_arrival <= '0;
            r_ov      <= 1'b0;
            r_pv      <= 1'b0;
            r_iss     <= '0;
        end else begin
            r_state <= n_state;

            // Scan address generator.
            if (scan_start) begin
                r_iss <= '0;
                r_pv  <= 1'b0;
            end else if (r_iss < CW'(MAX_ORDERS)) begin
                r_pidx <= r_iss[IW-1:0];
                r_pv   <= (r_state == S_FIND || r_state == S_WORST || r_state == S_SCAN);
                r_iss  <= r_iss + 1'b1;
            end else begin
                r_pv <= 1'b0;
            end

            if (scan_start) begin
                r_hit    <= 1'b0;
                r_wfound <= 1'b0;
                r_bb.vld <= 1'b0;
                r_ba.vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_kind   <= i_req.kind;
                        r_id     <= i_req.order_id;
                        r_side   <= i_req.side;
                        r_type   <= i_req.order_type;
                        r_price  <= i_req.price;
                        r_qty    <= i_req.quantity;
                        r_fak    <= (i_req.order_type == OT_FAK);
                        r_status <= STS_OK;
                    end
                end
                S_FIND: begin
                    if (slot_ok && r_rd.id == r_id) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_pidx;
                        r_hit_fak <= r_rd.fak;
                    end
                    if (scan_end) begin
                        if (r_hit || (slot_ok && r_rd.id == r_id)) begin
                            if (r_kind == KIND_ADD) begin
                                r_status <= STS_DUP;
                            end else begin
                                // Cancel, or the first half of a modify.
                                r_valid[(slot_ok && r_rd.id == r_id) ? r_pidx : r_hit_idx]
                                    <= 1'b0;
                                if (r_kind == KIND_MODIFY) begin
                                    r_fak <= (slot_ok && r_rd.id == r_id) ? r_rd.fak
                                                                          : r_hit_fak;
                                end
                            end
                        end else if (r_kind != KIND_ADD) begin
                            r_status <= STS_UNKNOWN;
                        end
                    end
                end
                S_WORST: begin
                    if (slot_ok && r_rd.side != r_side) begin
                        if (!r_wfound ||
                            (r_side ? (r_rd.price < r_wprice) : (r_rd.price > r_wprice))) begin
                            r_wprice <= r_rd.price;
                        end
                        r_wfound <= 1'b1;
                    end
                    if (scan_end) begin
                        // A market order rests as good till cancel at the worst price.
                        r_fak <= 1'b0;
                        if (slot_ok && r_rd.side != r_side &&
                            (!r_wfound ||
                             (r_side ? (r_rd.price < r_wprice) : (r_rd.price > r_wprice)))) begin
                            r_price <= r_rd.price;
                        end else begin
                            r_price <= r_wprice;
                        end
                        if (!(r_wfound || (slot_ok && r_rd.side != r_side))) begin
                            r_status <= STS_NOLIQ;
                        end
                    end
                end
                S_ALLOC: begin
                    if (free_found) begin
                        r_valid[free_idx] <= 1'b1;
                        r_arrival         <= r_arrival + 64'd1;
                    end else begin
                        r_status <= STS_FULL;
                    end
                end
                S_SCAN: begin
                    if (slot_ok) begin
                        if (!r_rd.side) begin
                            if (!r_bb.vld || r_rd.price > r_bb.s.price ||
                                (r_rd.price == r_bb.s.price &&
                                 r_rd.arrival < r_bb.s.arrival)) begin
                                r_bb <= '{vld: 1'b1, s: r_rd};
                                r_bi <= r_pidx;
                            end
                        end else begin
                            if (!r_ba.vld || r_rd.price < r_ba.s.price ||
                                (r_rd.price == r_ba.s.price &&
                                 r_rd.arrival < r_ba.s.arrival)) begin
                                r_ba <= '{vld: 1'b1, s: r_rd};
                                r_ai <= r_pidx;
                            end
                        end
                    end
                end
                S_TRADE: r_q <= q_min;
                S_WR_BID: if (r_bb.s.rem == r_q) r_valid[r_bi] <= 1'b0;
                S_WR_ASK: if (r_ba.s.rem == r_q) r_valid[r_ai] <= 1'b0;
                S_FAK: begin
                    // Fill-and-kill orders left at the head of either side are dropped.
                    if (r_bb.vld && r_bb.s.fak) r_valid[r_bi] <= 1'b0;
                    if (r_ba.vld && r_ba.s.fak) r_valid[r_ai] <= 1'b0;
                end
                default: r_q <= r_q;
            endcase

            // Output register.
            if (emit_trade || emit_stat) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit_trade) begin
            r_o_trade     <= 1'b1;
            r_o_bid_id    <= r_bb.s.id;
            r_o_bid_price <= r_bb.s.price;
            r_o_ask_id    <= r_ba.s.id;
            r_o_ask_price <= r_ba.s.price;
            r_o_fill      <= q_min;
            r_o_status    <= STS_OK;
            r_o_last      <= 1'b0;
        end else if (emit_stat) begin
            r_o_trade     <= 1'b0;
            r_o_bid_id    <= '0;
            r_o_bid_price <= '0;
            r_o_ask_id    <= '0;
            r_o_ask_price <= '0;
            r_o_fill      <= '0;
            r_o_status    <= r_status;
            r_o_last      <= 1'b1;
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.is_trade      = r_o_trade;
    assign o_res.bid_id        = r_o_bid_id;
    assign o_res.bid_price     = r_o_bid_price;
    assign o_res.ask_id        = r_o_ask_id;
    assign o_res.ask_price     = r_o_ask_price;
    assign o_res.fill_quantity = r_o_fill;
    assign o_res.status        = r_o_status;
    assign o_res.last          = r_o_last;

endmodule

// ===== tb/limit_order_book_matcher_test.sv =====
module limit_order_book_matcher_test;
    import lobm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = LOBM_MAX_ORDERS;
    localparam int RESULT_LIMIT = 64;

    // One request as presented on the request channel.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] order_id;
        logic        side;
        logic [1:0]  order_type;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_request;

    // One result item as expected on the result channel.
    typedef struct packed {
        logic        is_trade;
        logic [31:0] bid_id;
        logic [31:0] bid_price;
        logic [31:0] ask_id;
        logic [31:0] ask_price;
        logic [31:0] fill_quantity;
        logic [2:0]  status;
        logic        last;
    } t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lobm_req_if req_if ();
    lobm_res_if res_if ();

    limit_order_book_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The book as the checker sees it.
    logic        book_live [NSLOT];
    logic [31:0] book_id [NSLOT];
    logic        book_side [NSLOT];
    logic        book_fak [NSLOT];
    logic [31:0] book_price [NSLOT];
    logic [31:0] book_rem [NSLOT];
    logic [63:0] book_stamp [NSLOT];
    logic [63:0] stamp_next;

    t_request pending_reqs[$];
    t_fill    expected_fills[$];
    logic     any_error = 1'b0;
    int       n_requests = 0;
    int       n_trades = 0;
    int       n_results = 0;
    logic     quiet_mode = 1'b0;  // set during a stretch with no idling

    function automatic int lookup_id(logic [31:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (book_live[i] && book_id[i] == id) return i;
        return -1;
    endfunction

    // Price-time priority: highest bid or lowest ask, then oldest stamp.
    function automatic int best_order(logic sd);
        int b;
        b = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!book_live[i] || book_side[i] != sd) continue;
            if (b < 0) b = i;
            else if (book_price[i] != book_price[b]) begin
                if (sd == 1'b0 ? book_price[i] > book_price[b]
                               : book_price[i] < book_price[b]) b = i;
            end else if (book_stamp[i] < book_stamp[b]) b = i;
        end
        return b;
    endfunction

    task automatic push_fill(logic tr, logic [31:0] bid, logic [31:0] bp, logic [31:0] aid,
                             logic [31:0] ap, logic [31:0] q, logic [2:0] st, logic lst);
        t_fill f;
        f = '{tr, bid, bp, aid, ap, q, st, lst};
        expected_fills = {expected_fills, f};
    endtask

    task automatic queue_req(t_request r);
        pending_reqs = {pending_reqs, r};
    endtask

    // Cross the book after an insert, then drop a fill-and-kill at either top.
    task automatic cross_book(inout int n);
        int b;
        int a;
        logic [31:0] q;
        while (n < RESULT_LIMIT - 1) begin
            b = best_order(1'b0);
            a = best_order(1'b1);
            if (b < 0 || a < 0 || book_price[b] < book_price[a]) break;
            q = book_rem[b] < book_rem[a] ? book_rem[b] : book_rem[a];
            push_fill(1'b1, book_id[b], book_price[b], book_id[a], book_price[a], q,
                      STS_OK, 1'b0);
            n++;
            n_trades++;
            book_rem[b] -= q;
            book_rem[a] -= q;
            if (book_rem[b] == 0) book_live[b] = 1'b0;
            if (book_rem[a] == 0) book_live[a] = 1'b0;
        end
        b = best_order(1'b0);
        if (b >= 0 && book_fak[b]) book_live[b] = 1'b0;
        a = best_order(1'b1);
        if (a >= 0 && book_fak[a]) book_live[a] = 1'b0;
    endtask

    task automatic insert_order(t_request r, logic fak, logic mkt, inout int n,
                                output logic [2:0] st);
        int f;
        logic found;
        logic [31:0] px;
        st = STS_OK;
        px = r.price;
        if (lookup_id(r.order_id) >= 0) begin
            st = STS_DUP;
            return;
        end
        if (mkt) begin
            // Market order takes the worst opposite price and rests as plain limit.
            found = 1'b0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!book_live[i] || book_side[i] == r.side) continue;
                if (!found || (r.side == 1'b1 ? book_price[i] < px : book_price[i] > px))
                    px = book_price[i];
                found = 1'b1;
            end
            if (!found) begin
                st = STS_NOLIQ;
                return;
            end
            fak = 1'b0;
        end
        f = -1;
        for (int i = 0; i < NSLOT; i++)
            if (!book_live[i]) begin
                f = i;
                break;
            end
        if (f < 0) begin
            st = STS_FULL;
            return;
        end
        book_live[f] = 1'b1;
        book_id[f] = r.order_id;
        book_side[f] = r.side;
        book_fak[f] = fak;
        book_price[f] = px;
        book_rem[f] = r.quantity;
        book_stamp[f] = stamp_next;
        stamp_next++;
        cross_book(n);
    endtask

    task automatic predict_request(t_request r);
        int n;
        int idx;
        logic [2:0] st;
        logic fak;
        n = 0;
        st = STS_OK;
        if (r.kind == KIND_ADD) begin
            insert_order(r, r.order_type == OT_FAK, r.order_type == OT_MARKET, n, st);
        end else if (r.kind == KIND_CANCEL) begin
            idx = lookup_id(r.order_id);
            if (idx < 0) st = STS_UNKNOWN;
            else book_live[idx] = 1'b0;
        end else if (r.kind == KIND_MODIFY) begin
            idx = lookup_id(r.order_id);
            if (idx < 0) st = STS_UNKNOWN;
            else begin
                // The stored fill-and-kill flag survives; the new type is ignored.
                fak = book_fak[idx];
                book_live[idx] = 1'b0;
                insert_order(r, fak, 1'b0, n, st);
            end
        end
        push_fill(1'b0, '0, '0, '0, '0, '0, st, 1'b1);
    endtask

    // Driver: presents queued requests and predicts each one at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_request({req_if.kind, req_if.order_id, req_if.side,
                                 req_if.order_type, req_if.price, req_if.quantity});
                n_requests++;
            end
            if ((!req_if.valid || req_if.ready) ) begin
                if (pending_reqs.size() > 0 && (quiet_mode || $urandom_range(99) >= 18)) begin
                    t_request r;
                    r = pending_reqs[0];
                    pending_reqs.delete(0);
                    req_if.valid <= 1'b1;
                    {req_if.kind, req_if.order_id, req_if.side, req_if.order_type,
                     req_if.price, req_if.quantity} <= r;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                t_fill got;
                t_fill exp_f;
                got = {res_if.is_trade, res_if.bid_id, res_if.bid_price, res_if.ask_id,
                       res_if.ask_price, res_if.fill_quantity, res_if.status, res_if.last};
                n_results++;
                if (expected_fills.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    any_error = 1'b1;
                end else begin
                    exp_f = expected_fills[0];
                    expected_fills.delete(0);
                    if (got !== exp_f) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, exp_f, got);
                        if (got.is_trade !== exp_f.is_trade)
                            $display("  is_trade %0d vs %0d", exp_f.is_trade, got.is_trade);
                        if (got.fill_quantity !== exp_f.fill_quantity)
                            $display("  fill_quantity %0d vs %0d", exp_f.fill_quantity,
                                     got.fill_quantity);
                        if (got.status !== exp_f.status)
                            $display("  status %0d vs %0d", exp_f.status, got.status);
                        any_error = 1'b1;
                    end
                end
            end
            res_if.ready <= quiet_mode || ($urandom_range(99) >= 18);
        end
    end

    function automatic t_request mk(logic [1:0] k, logic [31:0] id, logic sd,
                                    logic [1:0] ty, logic [31:0] px, logic [31:0] q);
        t_request r;
        r = '{k, id, sd, ty, px, q};
        return r;
    endfunction

    // Random request drawn mostly around a small id pool and a narrow price band,
    // so orders cross and cancels and modifies hit resting ids.
    function automatic t_request random_request();
        t_request r;
        int pick;
        pick = $urandom_range(99);
        r.kind = pick < 60 ? KIND_ADD : (pick < 78 ? KIND_CANCEL :
                 (pick < 96 ? KIND_MODIFY : 2'd3));
        r.order_id = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(40));
        r.side = 1'($urandom_range(1));
        r.order_type = $urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2));
        r.price = ($urandom_range(19) == 0) ? $urandom() : 32'(100 + $urandom_range(10));
        r.quantity = ($urandom_range(19) == 0) ? $urandom() : 32'($urandom_range(20));
        return r;
    endfunction

    initial begin
        t_request r;
        for (int i = 0; i < NSLOT; i++) book_live[i] = 1'b0;
        stamp_next = '0;
        req_if.valid = 1'b0;
        req_if.kind = KIND_ADD;
        req_if.order_id = '0;
        req_if.side = 1'b0;
        req_if.order_type = '0;
        req_if.price = '0;
        req_if.quantity = '0;
        res_if.ready = 1'b0;

        // Directed part: empty-book market order, extremes, duplicates, zero quantity,
        // fill-and-kill, unknown ids, unused kind, type three, modify.
        queue_req(mk(KIND_ADD, 32'd1, 1'b0, OT_MARKET, 32'd5, 32'd10));
        queue_req(mk(KIND_ADD, 32'hFFFF_FFFF, 1'b1, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_req(mk(KIND_ADD, 32'hFFFF_FFFF, 1'b0, 2'd0, 32'd1, 32'd1));
        queue_req(mk(KIND_ADD, 32'd0, 1'b0, 2'd0, 32'd0, 32'd5));
        queue_req(mk(KIND_ADD, 32'd2, 1'b0, OT_MARKET, 32'd0, 32'd7));
        queue_req(mk(KIND_ADD, 32'd3, 1'b1, OT_MARKET, 32'd0, 32'd2));
        queue_req(mk(KIND_ADD, 32'd4, 1'b0, OT_FAK, 32'd50, 32'd3));
        queue_req(mk(KIND_ADD, 32'd5, 1'b1, 2'd3, 32'd50, 32'd0));
        queue_req(mk(KIND_ADD, 32'd6, 1'b0, 2'd0, 32'd60, 32'd4));
        queue_req(mk(KIND_ADD, 32'd7, 1'b1, OT_FAK, 32'd40, 32'd9));
        queue_req(mk(KIND_CANCEL, 32'd99, 1'b0, 2'd0, 32'd0, 32'd1));
        queue_req(mk(KIND_MODIFY, 32'd98, 1'b1, 2'd0, 32'd0, 32'd1));
        queue_req(mk(KIND_MODIFY, 32'hFFFF_FFFF, 1'b0, OT_MARKET, 32'hFFFF_FFFF, 32'd1));
        queue_req(mk(2'd3, 32'd0, 1'b1, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_req(mk(KIND_CANCEL, 32'd0, 1'b0, 2'd0, 32'd0, 32'd1));
        // Fill the table, overflow it, then sweep it with one large crossing order.
        for (int i = 0; i < NSLOT + 1; i++)
            queue_req(mk(KIND_ADD, 32'(1000 + i), 1'b1, 2'd0, 32'(200 + i % 3), 32'd1));
        queue_req(mk(KIND_CANCEL, 32'd1000, 1'b0, 2'd0, 32'd0, 32'd1));
        queue_req(mk(KIND_ADD, 32'd2000, 1'b0, 2'd0, 32'd300, 32'd1000));
        queue_req(mk(KIND_CANCEL, 32'd2000, 1'b0, 2'd0, 32'd0, 32'd1));
        queue_req(mk(KIND_CANCEL, 32'hFFFF_FFFF, 1'b0, 2'd0, 32'd0, 32'd1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 140; i++) begin
            r = random_request();
            queue_req(r);
        end

        // A stretch in the middle of the random part runs with no idling at all.
        wait (pending_reqs.size() < 110);
        quiet_mode = 1'b1;
        wait (pending_reqs.size() < 50);
        quiet_mode = 1'b0;

        wait (pending_reqs.size() == 0 && !req_if.valid);
        wait (expected_fills.size() == 0);
        repeat (500) @(posedge i_clk);

        $display("Ran %0d requests; %0d results checked, %0d of them trades.",
                 n_requests, n_results, n_trades);
        if (!any_error && expected_fills.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Even if every request swept a full book under heavy stalls, the run would end
    // well inside this limit.
    initial begin
        #100ms;
        $display("Timeout with %0d results still expected.", expected_fills.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lobm_pkg.sv
rtl/core/lobm_req_if.sv
rtl/core/lobm_res_if.sv
rtl/core/limit_order_book_matcher.sv
tb/limit_order_book_matcher_test.sv
